// ----- hw/rtl/art_pkg.sv -----
// Package for the address region table: payload structs, entry type,
// status, function and cell command codes. No dependencies.
package art_pkg;

    localparam int SLOT_W = 8;

    localparam logic [2:0] FN_DEFINE  = 3'd0;
    localparam logic [2:0] FN_LOOKUP  = 3'd1;
    localparam logic [2:0] FN_REMOVE  = 3'd2;
    localparam logic [2:0] FN_GROW    = 3'd3;
    localparam logic [2:0] FN_PLACE   = 3'd4;
    localparam logic [2:0] FN_LARGEST = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_WRAP     = 3'd3;
    localparam logic [2:0] ST_NOROOM   = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic [1:0] CMD_NOP  = 2'd0;
    localparam logic [1:0] CMD_INS  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;
    localparam logic [1:0] CMD_SIZE = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] address;
        logic [31:0] amount;
        logic [3:0]  permissions;
        logic [2:0]  region_kind;
        logic [3:0]  slot;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  result_slot;
        logic [31:0] result_base;
        logic [31:0] result_size;
        logic [3:0]  result_permissions;
        logic [2:0]  result_kind;
    } t_out;

    typedef struct packed {
        logic [31:0]       base;
        logic [31:0]       size;
        logic [3:0]        rights;
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot_id;
    } t_ent;

    typedef struct packed {
        logic [1:0] cmd;
        t_ent       ent;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/address_region_table_core.sv -----
// Address region table top level: sequencer that walks a chain of
// art_cell entries kept in ascending base order. Depends on art_pkg, art_cell.
//
//  channel | valid       | stall       | payload
//  input   | i_in_valid  | o_in_stall  | i_in_data  (art_pkg::t_in)
//  output  | o_out_valid | i_out_stall | o_out_data (art_pkg::t_out)
//
// One transaction at a time; the sequencer reads one chain cell per cycle.
// The input reopens in the same cycle that the result is loaded into the output register.
// Reset (synchronous, low) empties the table.
// A waiting result sits in the output register; a new transaction is taken
// meanwhile and holds in its final state only while that register is full and stalled.
module address_region_table_core #(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_BITS   = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  art_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output art_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import art_pkg::*;

    localparam int PW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [31:0] PG  = 32'(1) << PAGE_BITS;
    localparam logic [31:0] OFF = PG - 32'd1;
    localparam logic [CW-1:0] FULL = CW'(MAX_REGIONS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_DALN  = 4'd2;
    localparam logic [3:0] S_DSCAN = 4'd3;
    localparam logic [3:0] S_DINS  = 4'd4;
    localparam logic [3:0] S_LOOK  = 4'd5;
    localparam logic [3:0] S_FIND  = 4'd6;
    localparam logic [3:0] S_GSCAN = 4'd7;
    localparam logic [3:0] S_PFST  = 4'd8;
    localparam logic [3:0] S_PWALK = 4'd9;
    localparam logic [3:0] S_PLRG  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    function automatic t_out make_res(input logic [2:0] st, input t_ent e);
        t_out r;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.result_slot        = e.slot_id[3:0];
            r.result_base        = e.base;
            r.result_size        = e.size;
            r.result_permissions = e.rights;
            r.result_kind        = e.kind;
        end
        return r;
    endfunction

    logic [3:0]             r_state, n_state;
    t_in                    r_in, n_in;
    logic [CW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [MAX_REGIONS-1:0] r_slotv, n_slotv;
    logic [31:0]            r_db, n_db, r_ds, n_ds;
    logic [CW-1:0]          r_ins, n_ins;
    t_ent                   r_hit, n_hit;
    logic [CW-1:0]          r_q, n_q;
    logic [31:0]            r_ns, n_ns;
    t_ent                   r_prev, n_prev;
    logic [31:0]            r_cur, n_cur, r_best, n_best, r_best_at, n_best_at;
    t_out                   r_res, n_res;
    logic                   r_ov, n_ov;
    t_out                   r_out, n_out;

    t_cell_ctl     w_ctl;
    logic [PW-1:0] w_cpos;
    t_ent          w_ent [MAX_REGIONS];
    t_ent          w_rd;
    logic [PW-1:0] w_free;
    logic [PW-1:0] w_slot_ix;
    logic          w_slot_ok;
    logic [31:0]   w_end, w_lim, w_s1, w_b1, w_s2, w_gap;
    t_ent          w_new;

    genvar g;
    generate
        for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
            art_cell #(.NUM(MAX_REGIONS), .IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_cpos),
                .i_left  (w_ent[(g == 0) ? 0 : g - 1]),
                .i_right (w_ent[(g == MAX_REGIONS - 1) ? g : g + 1]),
                .o_ent   (w_ent[g])
            );
        end
    endgenerate

    assign w_rd      = w_ent[r_pos[PW-1:0]];
    assign w_slot_ix = PW'(r_in.slot);
    assign w_slot_ok = ({28'd0, r_in.slot} < 32'(MAX_REGIONS)) && r_slotv[w_slot_ix];

    always_comb begin
        w_free = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (!r_slotv[i]) w_free = PW'(i);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_slotv   = r_slotv;
        n_db      = r_db;
        n_ds      = r_ds;
        n_ins     = r_ins;
        n_hit     = r_hit;
        n_q       = r_q;
        n_ns      = r_ns;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_best    = r_best;
        n_best_at = r_best_at;
        n_res     = r_res;
        n_ov      = r_ov && i_out_stall;
        n_out     = r_out;
        w_ctl     = '0;
        w_cpos    = '0;
        w_end     = w_rd.base + w_rd.size;
        w_lim     = r_db + r_ds;
        w_s1      = r_ds + (r_db & OFF);
        w_b1      = r_db & ~OFF;
        w_s2      = (w_s1 + OFF) & ~OFF;
        w_gap     = (w_rd.base > r_cur) ? w_rd.base - r_cur : 32'd0;
        w_new.base    = r_db;
        w_new.size    = r_ds;
        w_new.rights  = r_in.permissions;
        w_new.kind    = r_in.region_kind;
        w_new.slot_id = SLOT_W'(w_free);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_pos     = '0;
                n_ins     = '0;
                n_cur     = PG;
                n_best    = '0;
                n_best_at = PG;
                n_db      = r_in.address;
                n_ds      = r_in.amount;
                n_state   = S_OUT;
                n_res     = make_res(ST_NOTFOUND, w_new);
                case (r_in.func) inside
                    FN_DEFINE:  n_state = S_DALN;
                    FN_LOOKUP:  n_state = S_LOOK;
                    FN_REMOVE,
                    FN_GROW:    if (w_slot_ok) n_state = S_FIND;
                    FN_PLACE:   n_state = S_PFST;
                    FN_LARGEST: n_state = S_PLRG;
                    default: ;
                endcase
            end
            S_DALN: begin
                n_db  = w_b1;
                n_ds  = w_s2;
                n_pos = '0;
                n_ins = '0;
                if (w_b1 == 32'd0 || w_s2 == 32'd0) begin
                    n_res   = make_res(ST_ZERO, w_new);
                    n_state = S_OUT;
                end else if (r_cnt == FULL) begin
                    n_res   = make_res(ST_NOROOM, w_new);
                    n_state = S_OUT;
                end else begin
                    n_state = S_DSCAN;
                end
            end
            S_DSCAN: begin
                if (r_pos == r_cnt) begin
                    n_state = S_DINS;
                end else if (r_db < w_end && w_lim > w_rd.base) begin
                    n_res   = make_res(ST_OVERLAP, w_new);
                    n_state = S_OUT;
                end else begin
                    if (w_rd.base <= r_db) n_ins = CW'(r_pos + 1'b1);
                    n_pos = CW'(r_pos + 1'b1);
                end
            end
            S_DINS: begin
                w_ctl.cmd       = CMD_INS;
                w_ctl.ent       = w_new;
                w_cpos          = r_ins[PW-1:0];
                n_slotv[w_free] = 1'b1;
                n_cnt           = CW'(r_cnt + 1'b1);
                n_res           = make_res(ST_OK, w_new);
                n_state         = S_OUT;
            end
            S_LOOK: begin
                if (r_pos == r_cnt) begin
                    n_res   = make_res(ST_NOTFOUND, w_new);
                    n_state = S_OUT;
                end else if (r_in.address >= w_rd.base && r_in.address < w_end) begin
                    n_res   = make_res(ST_OK, w_rd);
                    n_state = S_OUT;
                end else begin
                    n_pos = CW'(r_pos + 1'b1);
                end
            end
            S_FIND: begin
                if (w_rd.slot_id == SLOT_W'(r_in.slot) || r_pos == r_cnt) begin
                    n_hit = w_rd;
                    n_q   = r_pos;
                    n_ns  = w_rd.size + r_in.amount;
                    if (r_in.func == FN_REMOVE) begin
                        w_ctl.cmd          = CMD_DEL;
                        w_cpos             = r_pos[PW-1:0];
                        n_slotv[w_slot_ix] = 1'b0;
                        n_cnt              = CW'(r_cnt - 1'b1);
                        n_res              = make_res(ST_OK, w_rd);
                        n_state            = S_OUT;
                    end else if (w_rd.size + r_in.amount < w_rd.size) begin
                        n_res   = make_res(ST_WRAP, w_rd);
                        n_state = S_OUT;
                    end else begin
                        n_pos   = '0;
                        n_state = S_GSCAN;
                    end
                end else begin
                    n_pos = CW'(r_pos + 1'b1);
                end
            end
            S_GSCAN: begin
                if (r_pos == r_cnt) begin
                    w_ctl.cmd      = CMD_SIZE;
                    w_ctl.ent.size = r_ns;
                    w_cpos         = r_q[PW-1:0];
                    n_hit.size     = r_ns;
                    n_res          = make_res(ST_OK, n_hit);
                    n_state        = S_OUT;
                end else if (w_rd.slot_id != r_hit.slot_id && r_hit.base < w_end
                             && r_hit.base + r_ns > w_rd.base) begin
                    n_res   = make_res(ST_OVERLAP, w_rd);
                    n_state = S_OUT;
                end else begin
                    n_pos = CW'(r_pos + 1'b1);
                end
            end
            S_PFST: begin
                if (r_pos == r_cnt) begin
                    n_state = S_DALN;
                end else if (w_rd.base >= r_in.address) begin
                    if (w_rd.base - r_in.address >= r_in.amount) begin
                        n_state = S_DALN;
                    end else begin
                        n_prev  = w_rd;
                        n_pos   = CW'(r_pos + 1'b1);
                        n_state = S_PWALK;
                    end
                end else begin
                    n_pos = CW'(r_pos + 1'b1);
                end
            end
            S_PWALK: begin
                w_end = r_prev.base + r_prev.size;
                n_ds  = r_in.amount;
                n_db  = w_end;
                if (r_pos == r_cnt) begin
                    n_state = S_DALN;
                end else if (w_end + r_in.amount < r_prev.base) begin
                    n_res   = make_res(ST_WRAP, w_rd);
                    n_state = S_OUT;
                end else if (w_end + r_in.amount <= w_rd.base) begin
                    n_state = S_DALN;
                end else begin
                    n_prev = w_rd;
                    n_pos  = CW'(r_pos + 1'b1);
                end
            end
            S_PLRG: begin
                if (r_pos == r_cnt) begin
                    n_db = r_best_at;
                    n_ds = r_best;
                    if (r_best == 32'd0) begin
                        n_res   = make_res(ST_NOROOM, w_rd);
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DALN;
                    end
                end else begin
                    if (w_gap > r_best) begin
                        n_best    = w_gap;
                        n_best_at = r_cur;
                    end
                    n_cur = w_end;
                    n_pos = CW'(r_pos + 1'b1);
                end
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_slotv <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_slotv <= n_slotv;
            r_ov    <= n_ov;
        end
        r_in      <= n_in;
        r_pos     <= n_pos;
        r_db      <= n_db;
        r_ds      <= n_ds;
        r_ins     <= n_ins;
        r_hit     <= n_hit;
        r_q       <= n_q;
        r_ns      <= n_ns;
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        r_best    <= n_best;
        r_best_at <= n_best_at;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule

// ----- hw/rtl/art_cell.sv -----
// One cell of the base-ordered region chain: holds one entry, shifts toward
// a neighbor on insert or delete and can take a new size. Depends on art_pkg.
module art_cell #(
    parameter int NUM = 16,
    parameter int IDX = 0
) (
    input  logic                   i_clk,
    input  art_pkg::t_cell_ctl     i_ctl,
    input  logic [$clog2(NUM)-1:0] i_pos,
    input  art_pkg::t_ent          i_left,
    input  art_pkg::t_ent          i_right,
    output art_pkg::t_ent          o_ent
);
    import art_pkg::*;

    localparam int PW = $clog2(NUM);
    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    t_ent r_ent;
    t_ent n_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.cmd)
            CMD_INS: begin
                if (MY_IDX > i_pos) n_ent = i_left;
                else if (MY_IDX == i_pos) n_ent = i_ctl.ent;
            end
            CMD_DEL: begin
                if (MY_IDX >= i_pos) n_ent = i_right;
            end
            CMD_SIZE: begin
                if (MY_IDX == i_pos) n_ent.size = i_ctl.ent.size;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;
endmodule

// ----- hw/rtl/art_checker.sv -----
// Port-level checks for address_region_table_core, attached by bind.
// Depends on art_pkg.
module art_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input art_pkg::t_out o_out_data,
    input logic          i_out_stall
);
    import art_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled output payload changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
        o_out_data.result_base == 32'd0 && o_out_data.result_size == 32'd0
        && o_out_data.result_slot == 4'd0)
        else $error("failing result carries region fields");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_NOTFOUND)
        else $error("status code out of range");
endmodule

bind address_region_table_core art_checker u_art_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
